/* src/sud_pkg.sv */
package sud_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    typedef logic [DATA_WIDTH-1:0] word_t;

    // Status that the divide unit reports to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

/* src/sud_div_unit.sv */
module sud_div_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  sud_pkg::word_t    dividend,
    input  sud_pkg::word_t    divisor,
    output sud_pkg::div_stat_t stat,
    output sud_pkg::word_t    quotient,
    output sud_pkg::word_t    remainder
);
    import sud_pkg::*;

    word_t              rem_reg;
    word_t              quo_reg;
    word_t              dvs_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [DATA_WIDTH:0] shifted;
    logic [DATA_WIDTH:0] trial;
    logic                fits;
    word_t               rem_next;
    word_t               quo_next;

    // One restoring step: shift in the next dividend bit, subtract when it fits.
    always_comb begin
        shifted  = {rem_reg, quo_reg[DATA_WIDTH-1]};
        fits     = shifted >= {1'b0, dvs_reg};
        trial    = shifted - {1'b0, dvs_reg};
        rem_next = fits ? trial[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
        quo_next = {quo_reg[DATA_WIDTH-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dvs_reg  <= divisor;
                cnt_reg  <= CNT_W'(DATA_WIDTH - 1);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !start) else $error("divide unit restarted while busy");
    a_done_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && cnt_reg == '0 && !start |=> done_reg && !busy_reg)
        else $error("divide unit missed its final step");
    a_done_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg) else $error("done held longer than one cycle");

endmodule

/* src/signed_unsigned_divider_core.sv */
// The input transaction starts 32 shift-subtract steps of the divide unit; then the signs
// are fixed and the result is registered onto m_axis_tdata with m_axis_tvalid.
// The block takes no new input until the result transaction completes.
// Reset: aresetn is synchronous and active low; it returns the sequencer to idle
// and drops m_axis_tvalid. Operand and result registers are not reset.
module signed_unsigned_divider_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [2*sud_pkg::DATA_WIDTH-1:0] s_axis_tdata,   // [31:0] dividend, [63:32] divisor
    input  logic                            s_axis_tuser,   // [0] req_type (1 = signed)
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [2*sud_pkg::DATA_WIDTH-1:0] m_axis_tdata    // [31:0] quotient, [63:32] remainder
);
    import sud_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_OUT
    } state_t;

    state_t                  state_reg;
    logic                    q_neg_reg;
    logic                    r_neg_reg;
    logic                    d_zero_reg;
    logic                    m_tvalid_reg;
    logic [2*DATA_WIDTH-1:0] m_tdata_reg;

    logic        accept;
    logic        is_signed;
    word_t       n_in;
    word_t       d_in;
    logic        n_lt;
    logic        d_lt;
    logic        n_gt;
    logic        d_gt;
    word_t       n_mag;
    word_t       d_mag;

    div_stat_t   stat;
    word_t       quo_raw;
    word_t       rem_raw;
    word_t       quo_base;
    word_t       rem_base;
    word_t       quo_out;
    word_t       rem_out;

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign is_signed = s_axis_tuser;
    assign n_in      = s_axis_tdata[DATA_WIDTH-1:0];
    assign d_in      = s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH];

    // A zero operand carries no sign, so it never flips the quotient.
    always_comb begin
        n_lt  = is_signed && n_in[DATA_WIDTH-1];
        d_lt  = is_signed && d_in[DATA_WIDTH-1];
        n_gt  = !n_in[DATA_WIDTH-1] && (n_in != '0);
        d_gt  = !d_in[DATA_WIDTH-1] && (d_in != '0);
        n_mag = n_lt ? (~n_in + 1'b1) : n_in;
        d_mag = d_lt ? (~d_in + 1'b1) : d_in;
    end

    sud_div_unit u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (accept),
        .dividend  (n_mag),
        .divisor   (d_mag),
        .stat      (stat),
        .quotient  (quo_raw),
        .remainder (rem_raw)
    );

    // A zero divisor yields quotient zero and an all-ones remainder before sign fixup.
    always_comb begin
        quo_base = d_zero_reg ? '0 : quo_raw;
        rem_base = d_zero_reg ? '1 : rem_raw;
        quo_out  = q_neg_reg ? (~quo_base + 1'b1) : quo_base;
        rem_out  = r_neg_reg ? (~rem_base + 1'b1) : rem_base;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        q_neg_reg  <= is_signed && ((n_lt && d_gt) || (n_gt && d_lt));
                        r_neg_reg  <= n_lt;
                        d_zero_reg <= (d_in == '0);
                        state_reg  <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (stat.done) begin
                        m_tdata_reg  <= {rem_out, quo_out};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_axis_tready) begin
                        m_tvalid_reg <= 1'b0;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    m_tvalid_reg <= 1'b0;
                    state_reg    <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_axis_tready && m_axis_tvalid)) else $error("input taken while a result waits");
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> stat.busy) else $error("divide unit did not start");
    a_done_output: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.done && state_reg == ST_RUN |=> m_axis_tvalid)
        else $error("finished division not presented");
    a_zero_div_quo: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && d_zero_reg |-> m_axis_tdata[DATA_WIDTH-1:0] == '0)
        else $error("zero divisor gave nonzero quotient");

endmodule
